>>> hw/rtl/dtt_pkg.sv
// Shared types and constants for the difficulty-to-target converter.
package dtt_pkg;

   localparam int WORD_W    = 64;
   localparam int NUM_WORDS = 4;
   localparam int TARGET_W  = WORD_W * NUM_WORDS;
   localparam int DVD_W     = 48;
   localparam int NUM_CELLS = TARGET_W;
   localparam int IDX_W     = 2;
   localparam logic [IDX_W-1:0] LAST_IDX  = 2'd0;
   localparam logic [IDX_W-1:0] FIRST_IDX = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] difficulty_num;
      logic [WORD_W-1:0] difficulty_den;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  word_index;
      logic [WORD_W-1:0] target_word;
      logic              last_word;
      logic              saturated;
   } rsp_type;

   // one division step's worth of in-flight state
   typedef struct packed {
      logic                valid;
      logic                sat;
      logic [WORD_W-1:0]   divisor;
      logic [WORD_W-1:0]   rem;
      logic [DVD_W-1:0]    dvd;
      logic [TARGET_W-1:0] quo;
   } stage_type;

endpackage

>>> hw/rtl/dtt_cell.sv
// One restoring-division cell: produces one quotient bit per beat while the chain advances.
module dtt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  dtt_pkg::stage_type stage_in,
   output dtt_pkg::stage_type stage_out
);
   import dtt_pkg::*;

   stage_type         stage_ff;
   stage_type         stage_in_w;
   logic [WORD_W-1:0] shifted;
   logic [WORD_W:0]   diff;
   logic              qbit;

   // shift in the next dividend bit and try the subtract
   always_comb begin
      shifted = {stage_in.rem[WORD_W-2:0], stage_in.dvd[DVD_W-1]};
      diff    = {1'b0, shifted} - {1'b0, stage_in.divisor};
      qbit    = stage_in.rem[WORD_W-1] | ~diff[WORD_W];
      stage_in_w         = stage_in;
      stage_in_w.rem     = qbit ? diff[WORD_W-1:0] : shifted;
      stage_in_w.dvd     = {stage_in.dvd[DVD_W-2:0], 1'b0};
      stage_in_w.quo     = {stage_in.quo[TARGET_W-2:0], qbit};
   end

   // hold valid under reset, advance valid and data with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (advance) begin
         stage_ff.sat     <= stage_in_w.sat;
         stage_ff.divisor <= stage_in_w.divisor;
         stage_ff.rem     <= stage_in_w.rem;
         stage_ff.dvd     <= stage_in_w.dvd;
         stage_ff.quo     <= stage_in_w.quo;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> hw/rtl/dtt_serializer.sv
// Output register that sends the 256-bit target as four word beats.
module dtt_serializer (
   input  logic               clock,
   input  logic               reset,
   input  dtt_pkg::stage_type load_in,
   output logic               can_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dtt_pkg::rsp_type   rsp_data
);
   import dtt_pkg::*;

   logic                busy_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [TARGET_W-1:0] tgt_ff;
   logic                sat_ff;

   assign can_load  = !busy_ff || (rsp_ready && idx_ff == LAST_IDX);
   assign rsp_valid = busy_ff;

   // track whether a target is being sent
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (can_load) begin
         busy_ff <= load_in.valid;
      end
   end

   // load a fresh target or step to the next word
   always_ff @(posedge clock) begin
      if (can_load) begin
         idx_ff <= FIRST_IDX;
         sat_ff <= load_in.sat;
         tgt_ff <= load_in.sat ? {TARGET_W{1'b1}} : load_in.quo;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_data.word_index  = idx_ff;
      rsp_data.target_word = tgt_ff[idx_ff*WORD_W +: WORD_W];
      rsp_data.last_word   = (idx_ff == LAST_IDX);
      rsp_data.saturated   = sat_ff;
   end

   a_hold_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(idx_ff))
      else $error("word index moved while stalled");
   a_stay_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && idx_ff != LAST_IDX |=> busy_ff)
      else $error("target dropped before last word");
   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.target_word == {WORD_W{1'b1}})
      else $error("saturated word not all ones");

endmodule

>>> hw/rtl/difficulty_to_target.sv
// A request beat crosses the division chain and the response register to the first
// response word; later words follow as rsp_ready takes them. The four-word response
// register loads the next target as its last word is taken. The 256-cell division
// chain accepts a request every cycle and stalls as a whole when the response register
// cannot take its output. Reset clears all valid bits; no data is cleared.
module difficulty_to_target (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dtt_pkg::rsp_type rsp_data
);
   import dtt_pkg::*;

   stage_type stage [NUM_CELLS+1];
   logic      can_load;
   logic      advance;
   logic [DVD_W-1:0] product;

   // chain moves unless its tail is blocked
   assign advance   = !stage[NUM_CELLS].valid || can_load;
   assign req_ready = advance;

   // 0xFFFF * den = (den << 16) - den
   assign product = {req_data.difficulty_den[31:0], 16'b0}
                  - {16'b0, req_data.difficulty_den[31:0]};

   always_comb begin
      stage[0].valid   = req_valid;
      stage[0].sat     = (req_data.difficulty_num == '0)
                       || (req_data.difficulty_den == '0)
                       || (req_data.difficulty_den[WORD_W-1:32] != '0);
      stage[0].divisor = req_data.difficulty_num;
      stage[0].rem     = '0;
      stage[0].dvd     = product;
      stage[0].quo     = '0;
   end

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      dtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage[k]),
         .stage_out (stage[k+1])
      );
   end

   dtt_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load_in   (stage[NUM_CELLS]),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/difficulty_to_target_test.sv
// Self-checking testbench for the difficulty-to-target converter.
module difficulty_to_target_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dtt_pkg::*;

   localparam int LATENCY    = 257;
   localparam int WATCH_MAX  = 4000;
   localparam int RANDOM_CNT = 214;
   localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   difficulty_to_target u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   typedef struct {
      req_type req;
      logic    known;
      logic [255:0] target;
   } vector_type;

   rsp_type target_words[$];
   int      mismatches = 0;
   int      words_seen = 0;
   int      items_sent = 0;
   int      sat_seen = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_rsp = 1'b0;

   // compute the 256-bit target and its saturation flag
   function automatic logic [255:0] calc_target(input req_type r, output logic sat);
      logic [255:0] dividend;
      logic [255:0] quo;
      logic [64:0]  rem;
      sat = (r.difficulty_num == 0) || (r.difficulty_den == 0) ||
            (r.difficulty_den[63:32] != 0);
      quo = '1;
      if (!sat) begin
         dividend = 256'(64'hFFFF * r.difficulty_den) << 208;
         rem = '0;
         for (int b = 255; b >= 0; b--) begin
            rem = {rem[63:0], dividend[b]};
            if (rem >= {1'b0, r.difficulty_num}) begin
               rem = rem - {1'b0, r.difficulty_num};
               quo[b] = 1'b1;
            end else begin
               quo[b] = 1'b0;
            end
         end
      end
      return quo;
   endfunction

   // queue the four target words, most significant first
   function automatic void predict_target(input req_type r);
      logic [255:0] quo;
      logic         sat;
      rsp_type      w;
      quo = calc_target(r, sat);
      for (int k = 3; k >= 0; k--) begin
         w.word_index  = IDX_W'(k);
         w.target_word = quo[k*64 +: 64];
         w.last_word   = (w.word_index == LAST_IDX);
         w.saturated   = sat;
         target_words  = {target_words, w};
      end
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 9);
      r.difficulty_num = rand64();
      case (pick)
         0: r.difficulty_num = 64'($urandom_range(1, 16));
         1: r.difficulty_num = r.difficulty_num >> $urandom_range(0, 63);
         default: ;
      endcase
      if (r.difficulty_num == 0) r.difficulty_num = 64'd1;
      r.difficulty_den = {32'd0, $urandom} >> $urandom_range(0, 31);
      pick = $urandom_range(0, 19);
      if (pick == 0) r.difficulty_den = rand64();
      else if (pick == 1) r.difficulty_den = '0;
      else if (pick == 2) r.difficulty_num = '0;
      return r;
   endfunction

   // put one beat on the request channel and wait for it to go
   task automatic send_req(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_target(r);
      items_sent++;
   endtask

   task automatic idle_req(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // directed rows, exact targets given where plain
   vector_type directed[] = '{
      '{'{64'd0, 64'd1}, 1'b1, '1},
      '{'{64'd1, 64'd0}, 1'b1, '1},
      '{'{64'd0, 64'd0}, 1'b1, '1},
      '{'{64'd1, 64'h1_0000_0000}, 1'b1, '1},
      '{'{ONES64, ONES64}, 1'b1, '1},
      '{'{64'd1, 64'd1}, 1'b1, {32'd0, 16'hFFFF, 208'd0}},
      '{'{64'd2, 64'd2}, 1'b1, {32'd0, 16'hFFFF, 208'd0}},
      '{'{64'd1, 64'hFFFF_FFFF}, 1'b0, '0},
      '{'{ONES64, 64'd1}, 1'b0, '0},
      '{'{ONES64, 64'hFFFF_FFFF}, 1'b0, '0},
      '{'{64'h8000_0000_0000_0000, 64'd1}, 1'b0, '0},
      '{'{64'd3, 64'd7}, 1'b0, '0},
      '{'{64'h1_0000_0000, 64'd1}, 1'b0, '0},
      '{'{64'hFFFF, 64'd1}, 1'b1, {32'd0, 16'h0001, 208'd0}},
      '{'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA}, 1'b0, '0},
      '{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555}, 1'b0, '0}
   };

   // sender: reset, directed rows, then random traffic
   initial begin
      logic [255:0] tgt;
      logic         sat;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].known) begin
            // typed-in target must agree with the predictor
            tgt = calc_target(directed[i].req, sat);
            if (tgt != directed[i].target) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("row %0d: table %h predictor %h", i, directed[i].target, tgt);
            end
         end
         send_req(directed[i].req);
         idle_req(gap_len());
      end
      for (int i = 0; i < RANDOM_CNT; i++) begin
         send_req(random_req());
         // back-to-back beats once the long receiver hold has begun
         if (!hold_rsp) idle_req(gap_len());
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stalls, with one long hold-off to fill the pipe
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      repeat (40) @(posedge clock);
      forever begin
         if (items_sent >= 60 && !hold_rsp) begin
            hold_rsp = 1'b1;
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // check each response beat against the oldest expected word
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (target_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            e = target_words.pop_front();
            if (e.saturated && e.last_word) sat_seen++;
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected %p got %p", words_seen, e, rsp_data);
            end
         end
      end
   end

   // watchdog on accepted beats
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (!(stim_done && target_words.size() == 0) && idle_cycles < WATCH_MAX)
         @(posedge clock);
      if (idle_cycles >= WATCH_MAX) begin
         $display("timeout with %0d words pending", target_words.size());
         $display("difficulty_to_target_test failed");
      end else begin
         repeat (LATENCY + 20) @(posedge clock);
         $display("covered %0d requests (%0d saturated) and %0d response words",
                  items_sent, sat_seen, words_seen);
         if (mismatches == 0 && target_words.size() == 0)
            $display("difficulty_to_target_test passed");
         else
            $display("difficulty_to_target_test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_cell.sv
hw/rtl/dtt_serializer.sv
hw/rtl/difficulty_to_target.sv
tb/sv/difficulty_to_target_test.sv
